@@ rtl/sparse_chunked_sample_store_macros.svh @@
// assertion macros shared by the rtl
`ifndef SPARSE_CHUNKED_SAMPLE_STORE_MACROS_SVH
`define SPARSE_CHUNKED_SAMPLE_STORE_MACROS_SVH

// same-cycle implication
`define SCSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/scss_pkg.sv @@
package scss_pkg;

	// field widths
	localparam int OPCODE_W     = 2;
	localparam int POSITION_W   = 32;
	localparam int SAMPLE_W     = 32;
	localparam int SRC_CH_W     = 2;
	localparam int STATUS_W     = 3;
	localparam int SLOTS_USED_W = 7;
	localparam int CHANNELS_W   = 2;
	localparam int SLOT_LIMIT_W = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	// frames per chunk, a power of two so chunk and offset are bit fields
	localparam int CHUNK_FRAMES = 1024;

	// parameter defaults
	localparam int TABLE_CHUNKS_DEF = 4096;
	localparam int POOL_SLOTS_DEF   = 64;
	localparam int MAX_CHANNELS_DEF = 2;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 1'd1;

	// register reset values
	localparam logic [CHANNELS_W-1:0]   CHANNELS_RST   = 2'd2;
	localparam logic [SLOT_LIMIT_W-1:0] SLOT_LIMIT_RST = 7'd64;

	typedef struct packed {
		logic capture;
		logic execute;
		logic sweep_en;
		logic sweep_init;
		logic load_out;
	} scss_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic sweep_last;
	} scss_stat_t;

endpackage

@@ rtl/scss_ifs.sv @@
interface scss_frame_if;
	import scss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [OPCODE_W-1:0]   opcode;
	logic [POSITION_W-1:0] position;
	logic [SAMPLE_W-1:0]   sample_ch0;
	logic [SAMPLE_W-1:0]   sample_ch1;
	logic [SRC_CH_W-1:0]   src_channels;
	logic                  end_of_run;

	modport source (output valid, opcode, position, sample_ch0, sample_ch1, src_channels,
		end_of_run, input ready);
	modport sink (input valid, opcode, position, sample_ch0, sample_ch1, src_channels,
		end_of_run, output ready);
endinterface

interface scss_result_if;
	import scss_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_W-1:0]     read_ch0;
	logic [SAMPLE_W-1:0]     read_ch1;
	logic [STATUS_W-1:0]     status;
	logic                    exhausted;
	logic [SLOTS_USED_W-1:0] slots_used;
	logic                    run_end;

	modport source (output valid, read_ch0, read_ch1, status, exhausted, slots_used, run_end,
		input ready);
	modport sink (input valid, read_ch0, read_ch1, status, exhausted, slots_used, run_end,
		output ready);
endinterface

interface scss_cfg_if;
	import scss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/scss_ctrl.sv @@
module scss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	output scss_pkg::scss_cmd_t   cmd,
	input  scss_pkg::scss_stat_t  stat
);
	import scss_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_LOOKUP,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		frame_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep_en   = 1'b1;
				cmd.sweep_init = 1'b1;
			end
			S_IDLE: begin
				frame_ready = 1'b1;
			end
			S_LOOKUP: begin
				cmd.execute = 1'b1;
			end
			S_SWEEP: begin
				cmd.sweep_en = 1'b1;
			end
			S_FINISH: begin
				cmd.load_out = can_load;
				frame_ready  = can_load;
			end
			default: begin
			end
		endcase
		cmd.capture = frame_ready && frame_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (stat.sweep_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd.capture) state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					state_q <= stat.is_clear ? S_SWEEP : S_FINISH;
				end
				S_SWEEP: begin
					if (stat.sweep_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.load_out) state_q <= cmd.capture ? S_LOOKUP : S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

@@ rtl/scss_datapath.sv @@
module scss_datapath #(
	parameter int TABLE_CHUNKS = scss_pkg::TABLE_CHUNKS_DEF,
	parameter int POOL_SLOTS   = scss_pkg::POOL_SLOTS_DEF,
	parameter int MAX_CHANNELS = scss_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scss_pkg::scss_cmd_t                 cmd,
	output scss_pkg::scss_stat_t                stat,
	input  logic                                cfg_we,
	input  logic [scss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [scss_pkg::OPCODE_W-1:0]       opcode,
	input  logic [scss_pkg::POSITION_W-1:0]     position,
	input  logic [scss_pkg::SAMPLE_W-1:0]       sample_ch0,
	input  logic [scss_pkg::SAMPLE_W-1:0]       sample_ch1,
	input  logic [scss_pkg::SRC_CH_W-1:0]       src_channels,
	input  logic                                end_of_run,
	output logic [scss_pkg::SAMPLE_W-1:0]       read_ch0,
	output logic [scss_pkg::SAMPLE_W-1:0]       read_ch1,
	output logic [scss_pkg::STATUS_W-1:0]       status,
	output logic                                exhausted,
	output logic [scss_pkg::SLOTS_USED_W-1:0]   slots_used,
	output logic                                run_end
);
	import scss_pkg::*;

	// chunk frames is a power of two: chunk and offset are bit fields
	localparam int OFF_W      = $clog2(CHUNK_FRAMES);
	localparam int MAP_AW     = $clog2(TABLE_CHUNKS);
	localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
	localparam int LIM_W      = (CNT_W > SLOT_LIMIT_W) ? CNT_W : SLOT_LIMIT_W;
	localparam int POOL_DEPTH = POOL_SLOTS * CHUNK_FRAMES;
	localparam int POOL_AW    = $clog2(POOL_DEPTH);
	localparam int CHUNK_W    = POSITION_W - OFF_W;
	localparam int SWEEP_N    = (POOL_DEPTH > TABLE_CHUNKS) ? POOL_DEPTH : TABLE_CHUNKS;
	localparam int SWEEP_W    = $clog2(SWEEP_N);
	localparam int HI_LANE    = (MAX_CHANNELS > 1) ? 1 : 0;
	localparam int EC_W       = 4;

	// memories
	logic [SLOT_W:0]                            map_mem  [TABLE_CHUNKS];
	logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]      pool_mem [POOL_DEPTH];

	// config and control state
	logic [CHANNELS_W-1:0]   channels_q;
	logic [SLOT_LIMIT_W-1:0] slot_limit_q;
	logic [CNT_W-1:0]        used_q;
	logic                    exhausted_q;
	logic                    stopped_q;
	logic [SWEEP_W-1:0]      sweep_q;

	// item registers
	logic [OPCODE_W-1:0]   op_q;
	logic [POSITION_W-1:0] pos_q;
	logic [SAMPLE_W-1:0]   s0_q;
	logic [SAMPLE_W-1:0]   s1_q;
	logic [SRC_CH_W-1:0]   nsrc_q;
	logic                  last_q;
	logic [SLOT_W:0]       map_rd_q;

	// result registers
	logic [STATUS_W-1:0]                   status_q;
	logic                                  rd0_ok_q;
	logic                                  rd1_ok_q;
	logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] pool_rd_q;

	// execute decode
	logic [CHUNK_W-1:0]    chunk;
	logic                  beyond;
	logic [MAP_AW-1:0]     map_idx;
	logic [OFF_W-1:0]      offset;
	logic [SRC_CH_W-1:0]   nsrc_eff;
	logic                  map_valid;
	logic [SLOT_W-1:0]     map_slot;
	logic [LIM_W-1:0]      limit_ext;
	logic [LIM_W-1:0]      eff_lim;
	logic [EC_W-1:0]       eff_ch;
	logic [STATUS_W-1:0]   status_n;
	logic                  fail;
	logic                  alloc;
	logic                  pool_we;
	logic                  rd_ok;
	logic                  exhaust_set;
	logic [SLOT_W-1:0]     slot_sel;
	logic [POOL_AW-1:0]    pool_addr;

	logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_data;
	logic [MAX_CHANNELS-1:0]               lane_en;

	logic                  map_we;
	logic [MAP_AW-1:0]     map_waddr;
	logic [SLOT_W:0]       map_wdata;
	logic                  sweep_in_map;
	logic                  pool_sweep;
	logic [POOL_AW-1:0]    pool_waddr;

	assign chunk     = pos_q[POSITION_W-1:OFF_W];
	assign beyond    = {1'b0, chunk} >= (CHUNK_W + 1)'(TABLE_CHUNKS);
	assign map_idx   = pos_q[OFF_W +: MAP_AW];
	assign offset    = pos_q[OFF_W-1:0];
	assign nsrc_eff  = (nsrc_q == 2'd3) ? 2'd2 : nsrc_q;
	assign map_valid = map_rd_q[SLOT_W];
	assign map_slot  = map_rd_q[SLOT_W-1:0];
	assign limit_ext = LIM_W'(slot_limit_q);
	assign eff_lim   = (limit_ext > LIM_W'(POOL_SLOTS)) ? LIM_W'(POOL_SLOTS) : limit_ext;

	always_comb begin
		if (channels_q == '0) begin
			eff_ch = EC_W'(1);
		end else if (EC_W'(channels_q) > EC_W'(MAX_CHANNELS)) begin
			eff_ch = EC_W'(MAX_CHANNELS);
		end else begin
			eff_ch = EC_W'(channels_q);
		end
	end

	always_comb begin
		status_n    = ST_OK;
		fail        = 1'b0;
		alloc       = 1'b0;
		pool_we     = 1'b0;
		rd_ok       = 1'b0;
		exhaust_set = 1'b0;
		slot_sel    = map_slot;
		case (op_q)
			OP_CLEAR: begin
			end
			OP_WRITE, OP_READ: begin
				if (stopped_q) begin
					status_n = ST_SKIPPED;
				end else if (beyond) begin
					status_n = ST_BEYOND;
					fail     = 1'b1;
				end else if (op_q == OP_WRITE) begin
					if (nsrc_q == '0) begin
						status_n = ST_SKIPPED;
					end else if (!map_valid) begin
						if (LIM_W'(used_q) >= eff_lim) begin
							exhaust_set = 1'b1;
							status_n    = ST_EXHAUSTED;
							fail        = 1'b1;
						end else begin
							alloc    = 1'b1;
							pool_we  = 1'b1;
							slot_sel = used_q[SLOT_W-1:0];
						end
					end else begin
						pool_we = 1'b1;
					end
				end else begin
					if (!map_valid || LIM_W'(map_slot) >= eff_lim) begin
						status_n = ST_UNMAPPED;
					end else begin
						rd_ok = 1'b1;
					end
				end
			end
			default: begin
				status_n = ST_SKIPPED;
			end
		endcase
	end

	assign pool_addr = POOL_AW'({slot_sel, offset});

	// stored channel c takes source min(c, sources - 1)
	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			lane_data[c] = (c == 0 || nsrc_eff == 2'd1) ? s0_q : s1_q;
			lane_en[c]   = EC_W'(c) < eff_ch;
		end
	end

	assign stat.is_clear   = (op_q == OP_CLEAR);
	assign stat.sweep_last = cmd.sweep_init ? (sweep_q == SWEEP_W'(SWEEP_N - 1))
		: (sweep_q == SWEEP_W'(TABLE_CHUNKS - 1));

	assign sweep_in_map = {1'b0, sweep_q} < (SWEEP_W + 1)'(TABLE_CHUNKS);
	assign pool_sweep   = cmd.sweep_en && cmd.sweep_init
		&& ({1'b0, sweep_q} < (SWEEP_W + 1)'(POOL_DEPTH));
	assign map_we       = (cmd.sweep_en && sweep_in_map) || (cmd.execute && alloc);
	assign map_waddr    = cmd.sweep_en ? sweep_q[MAP_AW-1:0] : map_idx;
	assign map_wdata    = cmd.sweep_en ? '0 : {1'b1, slot_sel};
	assign pool_waddr   = pool_sweep ? sweep_q[POOL_AW-1:0] : pool_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q   <= CHANNELS_RST;
			slot_limit_q <= SLOT_LIMIT_RST;
			used_q       <= '0;
			exhausted_q  <= 1'b0;
			stopped_q    <= 1'b0;
			sweep_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNELS:   channels_q   <= cfg_data[CHANNELS_W-1:0];
					REG_SLOT_LIMIT: slot_limit_q <= cfg_data[SLOT_LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.execute) begin
				if (op_q == OP_CLEAR) begin
					used_q      <= '0;
					exhausted_q <= 1'b0;
					stopped_q   <= 1'b0;
				end else begin
					if (alloc) used_q <= used_q + 1'b1;
					if (exhaust_set) exhausted_q <= 1'b1;
					if (op_q == OP_WRITE || op_q == OP_READ) begin
						if (last_q) begin
							stopped_q <= 1'b0;
						end else if (fail) begin
							stopped_q <= 1'b1;
						end
					end
				end
			end
			if (cmd.sweep_en) begin
				sweep_q <= stat.sweep_last ? '0 : sweep_q + 1'b1;
			end
		end
	end

	// item capture and map lookup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			pos_q    <= position;
			s0_q     <= sample_ch0;
			s1_q     <= sample_ch1;
			nsrc_q   <= src_channels;
			last_q   <= end_of_run;
			map_rd_q <= map_mem[position[OFF_W +: MAP_AW]];
		end
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
	end

	// sample pool, one write and one read port
	always_ff @(posedge clk) begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			if (pool_sweep || (cmd.execute && pool_we && lane_en[c])) begin
				pool_mem[pool_waddr][c] <= pool_sweep ? '0 : lane_data[c];
			end
		end
		if (cmd.execute) begin
			pool_rd_q <= pool_mem[pool_addr];
			status_q  <= status_n;
			rd0_ok_q  <= rd_ok;
			rd1_ok_q  <= rd_ok && (eff_ch >= EC_W'(2));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_ch0   <= rd0_ok_q ? pool_rd_q[0] : '0;
			read_ch1   <= rd1_ok_q ? pool_rd_q[HI_LANE] : '0;
			status     <= status_q;
			exhausted  <= exhausted_q;
			slots_used <= SLOTS_USED_W'(used_q);
			run_end    <= last_q;
		end
	end

endmodule

@@ rtl/sparse_chunked_sample_store.sv @@
// sparse chunked sample store
// frames: valid/ready channel, one item per frame (write, read or clear).
// results: valid/ready channel, exactly one item per accepted frame, in order.
// cfg: write channel, always ready; index 0 channels in use, index 1 slot limit.
// write the registers only while no frame is in flight.
// result path: a write or read frame passes the map lookup, the pool access
// and the output register; a clear frame sweeps the chunk map in between.
// throughput: a frame is taken only after the last one's map lookup and pool
// access, both registered-read memories with one read and one write port.
// reset: a clearing pass zeroes the sample pool and unmaps the chunk map,
// max(POOL_SLOTS * CHUNK_FRAMES, TABLE_CHUNKS) addresses (65536 at defaults);
// frames are not accepted until it ends, configuration writes are.
// stall: the result sits in an output register; the next frame is taken in
// the cycle the held result is taken, and waits after its lookup otherwise.
// the chunk size is fixed at CHUNK_FRAMES frames, a power of two.
`include "sparse_chunked_sample_store_macros.svh"

module sparse_chunked_sample_store #(
	parameter int TABLE_CHUNKS = scss_pkg::TABLE_CHUNKS_DEF,
	parameter int POOL_SLOTS   = scss_pkg::POOL_SLOTS_DEF,
	parameter int MAX_CHANNELS = scss_pkg::MAX_CHANNELS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	scss_cfg_if.sink       cfg,
	scss_frame_if.sink     frames,
	scss_result_if.source  results
);
	import scss_pkg::*;

	scss_cmd_t  cmd;
	scss_stat_t stat;

	assign cfg.ready = 1'b1;

	scss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frames.valid),
		.frame_ready  (frames.ready),
		.result_valid (results.valid),
		.result_ready (results.ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	scss_datapath #(
		.TABLE_CHUNKS (TABLE_CHUNKS),
		.POOL_SLOTS   (POOL_SLOTS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg.valid && cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.opcode       (frames.opcode),
		.position     (frames.position),
		.sample_ch0   (frames.sample_ch0),
		.sample_ch1   (frames.sample_ch1),
		.src_channels (frames.src_channels),
		.end_of_run   (frames.end_of_run),
		.read_ch0     (results.read_ch0),
		.read_ch1     (results.read_ch1),
		.status       (results.status),
		.exhausted    (results.exhausted),
		.slots_used   (results.slots_used),
		.run_end      (results.run_end)
	);

	`SCSS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, frames.valid && frames.ready, !frames.ready, "frame taken during lookup")
	`SCSS_ASSERT_IMP(a_exhaust_sticky, clk, arst_n, results.valid && results.status == ST_EXHAUSTED, results.exhausted, "exhausted status without flag")
	`SCSS_ASSERT_IMP(a_zero_on_fail, clk, arst_n, results.valid && results.status != ST_OK, results.read_ch0 == '0 && results.read_ch1 == '0, "read data on failed item")

endmodule
